/* rtl/wcf_pkg.sv */
// Package for the waypoint capture follower.
// Holds op and status codes, the sequencer state type and default sizes.
// No dependencies.
package wcf_pkg;

  // Default table size and coordinate width (signed Q15.8 metres)
  localparam int WCF_TABLE_DEPTH = 128;
  localparam int WCF_COORD_BITS  = 24;

  // Capture radius after reset: 4 m in unsigned Q8.8
  localparam logic [15:0] WCF_RADIUS_RST = 16'd1024;

  // Op codes carried on in_tuser
  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_POSITION = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Status codes carried on out_tuser
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_CMP,
    ST_RESP
  } wcf_state_t;

endpackage

/* rtl/wcf_mem.sv */
// Waypoint table: single write port, single read port, registered read data.
// Each entry holds one waypoint as {y, x}. No package dependency.
module wcf_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/wcf_dist.sv */
// Capture test: squared distance from car to target against squared radius.
// Stage 1 absolute offsets, stage 2 squares, then add and compare.
// No package dependency.
module wcf_dist #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] car_x,
  input  logic signed [COORD_BITS-1:0] car_y,
  input  logic signed [COORD_BITS-1:0] tgt_x,
  input  logic signed [COORD_BITS-1:0] tgt_y,
  input  logic [15:0]                  radius,
  output logic                         hit
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = (DW > 17) ? DW : 17;

  logic signed [DW-1:0] dxs, dys;
  logic [DW-1:0]        dxa, dya;
  logic [EW-1:0]        dxe, dye;
  logic                 far;

  logic [15:0] dx_r, dy_r;
  logic        far1_r;
  logic [31:0] sqx_r, sqy_r, r2_r;
  logic        far2_r;
  logic [32:0] sum;

  // stage 1: absolute axis offsets, out of range beyond 16 bits
  always_comb begin
    dxs = DW'(car_x) - DW'(tgt_x);
    dys = DW'(car_y) - DW'(tgt_y);
    dxa = dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
    dya = dys[DW-1] ? DW'(-dys) : DW'(dys);
    dxe = EW'(dxa);
    dye = EW'(dya);
    far = (|dxe[EW-1:16]) | (|dye[EW-1:16]);
  end

  always_ff @(posedge clk) begin
    dx_r   <= dxe[15:0];
    dy_r   <= dye[15:0];
    far1_r <= far;
  end

  // stage 2: squares and squared radius
  always_ff @(posedge clk) begin
    sqx_r  <= 32'(dx_r) * 32'(dx_r);
    sqy_r  <= 32'(dy_r) * 32'(dy_r);
    r2_r   <= 32'(radius) * 32'(radius);
    far2_r <= far1_r;
  end

  // final add and strict compare
  assign sum = 33'(sqx_r) + 33'(sqy_r);
  assign hit = !far2_r && (sum < 33'(r2_r));

endmodule

/* rtl/waypoint_capture_follower.sv */
// Top level of the waypoint capture follower: sequencer, target state and
// result register around the waypoint table (wcf_mem) and capture test
// (wcf_dist). Depends on wcf_pkg.
//
//  channel | dir | handshake           | content
//  --------+-----+---------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready | op on tuser, car or waypoint on tdata
//  out_    | out | tvalid/tready       | target, index, laps, flag; status
//  cfg_    | in  | cfg_valid/cfg_ready | capture radius, Q8.8
//
// Steps per word, set by the single table read port and the capture test:
// clear, unused op or update on an empty table go from idle to response;
// append adds a read; update adds diff, square, compare and a read on capture.
// A word is taken while the previous result still waits on out_; a result
// held by out_tready stalls the sequencer in its response step.
// Reset (rst_n, synchronous) empties the table, clears index and laps and
// sets the radius to 4 m; table contents are not cleared.
module waypoint_capture_follower #(
  parameter int TABLE_DEPTH = wcf_pkg::WCF_TABLE_DEPTH,
  parameter int COORD_BITS  = wcf_pkg::WCF_COORD_BITS,
  localparam int IDX_W  = $clog2(TABLE_DEPTH),
  localparam int IN_DW  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_FW = 2 * COORD_BITS + IDX_W + 17,
  localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: point_x, point_y
  input  logic [IN_DW-1:0]  in_tdata,
  // in_tuser: op
  input  logic [1:0]        in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // out_tdata: target_x, target_y, target_index, laps, captured
  output logic [OUT_DW-1:0] out_tdata,
  // out_tuser: status
  output logic [1:0]        out_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       cfg_data,
  input  logic              cfg_valid,
  output logic              cfg_ready
);

  import wcf_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  wcf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     tgt_r;
  logic [15:0]          laps_r;
  logic [15:0]          radius_r;
  logic [1:0]           status_r;
  logic                 capt_r;
  logic signed [CW-1:0] px_r, py_r;

  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [15:0]          out_laps_r;
  logic                 out_capt_r;
  logic [1:0]           out_stat_r;
  logic                 out_valid_r;

  logic                 in_fire, out_free, table_full, capt_hit;
  logic                 mem_we, mem_re, load_out;
  logic [2*CW-1:0]      rd_data;
  logic signed [CW-1:0] rd_x, rd_y;
  logic [CNT_W-1:0]     tgt_inc;
  logic                 tgt_wrap;

  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign rd_x       = rd_data[CW-1:0];
  assign rd_y       = rd_data[2*CW-1:CW];
  assign tgt_inc    = CNT_W'(tgt_r) + CNT_W'(1);
  assign tgt_wrap   = (tgt_inc >= count_r);
  assign cfg_ready  = 1'b1;

  // waypoint table
  wcf_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (2 * CW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_tdata[2*CW-1:0]),
    .rd_en   (mem_re),
    .rd_addr (tgt_r),
    .rd_data (rd_data)
  );

  // capture test against the target just read
  wcf_dist #(
    .COORD_BITS (CW)
  ) u_dist (
    .clk    (clk),
    .car_x  (px_r),
    .car_y  (py_r),
    .tgt_x  (rd_x),
    .tgt_y  (rd_y),
    .radius (radius_r),
    .hit    (capt_hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_tuser == OP_APPEND) begin
            state_nxt = ST_READ;
          end else if (in_tuser == OP_POSITION && count_r != '0) begin
            state_nxt = ST_DIFF;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_READ: state_nxt = ST_RESP;
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_CMP;
      ST_CMP:  state_nxt = capt_hit ? ST_READ : ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_we    = in_tvalid && (in_tuser == OP_APPEND) && !table_full;
        mem_re    = in_tvalid && (in_tuser != OP_APPEND);
      end
      ST_READ: mem_re   = 1'b1;
      ST_RESP: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= WCF_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_data;
    end
  end

  // table fill, target index and lap count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tgt_r   <= '0;
      laps_r  <= '0;
    end else if (in_fire) begin
      if (in_tuser == OP_APPEND && !table_full) begin
        count_r <= count_r + CNT_W'(1);
      end else if (in_tuser == OP_CLEAR) begin
        count_r <= '0;
        tgt_r   <= '0;
        laps_r  <= '0;
      end
    end else if (state_r == ST_CMP && capt_hit) begin
      if (tgt_wrap) begin
        tgt_r  <= '0;
        laps_r <= laps_r + 16'd1;
      end else begin
        tgt_r <= tgt_inc[IDX_W-1:0];
      end
    end
  end

  // per-word fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r   <= in_tdata[CW-1:0];
      py_r   <= in_tdata[2*CW-1:CW];
      capt_r <= 1'b0;
      priority if (in_tuser == OP_APPEND && table_full) begin
        status_r <= STAT_FULL;
      end else if (in_tuser == OP_POSITION && count_r == '0) begin
        status_r <= STAT_EMPTY;
      end else begin
        status_r <= STAT_OK;
      end
    end else if (state_r == ST_CMP && capt_hit) begin
      capt_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r    <= (count_r != '0) ? rd_x : '0;
      out_y_r    <= (count_r != '0) ? rd_y : '0;
      out_idx_r  <= tgt_r;
      out_laps_r <= laps_r;
      out_capt_r <= capt_r;
      out_stat_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_capt_r, out_laps_r, out_idx_r, out_y_r, out_x_r});
  assign out_tuser  = out_stat_r;

  // checks
  a_tgt_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CNT_W'(tgt_r) < count_r))
    else $error("target index at or past waypoint count");

  a_empty_tgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (tgt_r == '0))
    else $error("target index nonzero on empty table");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("waypoint count beyond table depth");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result loaded outside response step");

  a_capture_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_capt_r) |-> (out_stat_r == STAT_OK))
    else $error("capture flagged with error status");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for waypoint_capture_follower: a predictor class tracks the
// waypoint table, target index, laps and capture radius and checks each result word.
// Depends on wcf_pkg and the waypoint_capture_follower RTL.
module tb_top;
  import wcf_pkg::*;

  localparam int DEPTH = WCF_TABLE_DEPTH;
  localparam int IN_W  = 48;
  localparam int OUT_W = 72;
  localparam int QUIET_LIMIT = 4000;

  // op code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [23:0] C_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] C_MIN = 24'sh80_0000;

  // one result word, field by field
  typedef struct packed {
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic [6:0]         idx;
    logic [15:0]        laps;
    logic               captured;
    logic [1:0]         status;
  } target_report_t;

  // Tracks the follower state and holds the target reports still owed by the block
  class capture_predictor;
    logic signed [23:0] way_x [DEPTH];
    logic signed [23:0] way_y [DEPTH];
    int                 count;
    int                 tgt;
    logic [15:0]        laps;
    logic [15:0]        radius;
    target_report_t     awaited[$];
    int                 fail_count;

    function new();
      count      = 0;
      tgt        = 0;
      laps       = '0;
      radius     = WCF_RADIUS_RST;
      fail_count = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // update the state for one accepted input word and queue its report
    function void track_word(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y);
      target_report_t rep;
      longint dx, dy, r2;
      rep = '0;
      case (op)
        OP_APPEND: begin
          if (count < DEPTH) begin
            way_x[count] = x;
            way_y[count] = y;
            count++;
          end else begin
            rep.status = STAT_FULL;
          end
        end
        OP_POSITION: begin
          if (count == 0) begin
            rep.status = STAT_EMPTY;
          end else begin
            dx = longint'(x) - longint'(way_x[tgt]);
            dy = longint'(y) - longint'(way_y[tgt]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            r2 = longint'(radius) * longint'(radius);
            // strictly inside the radius; huge offsets never capture
            if (dx < 65536 && dy < 65536 && dx * dx + dy * dy < r2) begin
              rep.captured = 1'b1;
              if (tgt + 1 >= count) begin
                tgt  = 0;
                laps = laps + 16'd1;
              end else begin
                tgt++;
              end
            end
          end
        end
        OP_CLEAR: begin
          count = 0;
          tgt   = 0;
          laps  = '0;
        end
        default: ;
      endcase
      if (count != 0) begin
        rep.tx = way_x[tgt];
        rep.ty = way_y[tgt];
      end
      rep.idx  = 7'(tgt);
      rep.laps = laps;
      awaited.push_back(rep);
    endfunction

    // compare one accepted result word with the oldest queued report
    function void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
      target_report_t want, got;
      got.tx       = data[23:0];
      got.ty       = data[47:24];
      got.idx      = data[54:48];
      got.laps     = data[70:55];
      got.captured = data[71];
      got.status   = user;
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: tdata=%h tuser=%0d", data, user);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $write("mismatch (exp/act): x %0d/%0d y %0d/%0d idx %0d/%0d laps %0d/%0d",
                 want.tx, got.tx, want.ty, got.ty, want.idx, got.idx,
                 want.laps, got.laps);
          $display(" captured %0b/%0b status %0d/%0d",
                   want.captured, got.captured, want.status, got.status);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic [IN_W-1:0]  in_tdata  = '0;
  logic [1:0]       in_tuser  = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      cfg_data  = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;

  capture_predictor tracker;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;

  waypoint_capture_follower u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),   // point_x, point_y
    .in_tuser   (in_tuser),   // op
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),  // target_x, target_y, target_index, laps, captured
    .out_tuser  (out_tuser),  // status
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result checker, receiver stalls and watchdog on accepted words
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic signed [23:0] wrap_coord(longint v);
    logic [63:0] t;
    t = v;
    return t[23:0];
  endfunction

  function automatic logic signed [23:0] rand_coord();
    return 24'($urandom());
  endfunction

  // waypoints: mostly anywhere, sometimes at the range ends, zero or minus one
  function automatic logic signed [23:0] pick_waypoint();
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) return rand_coord();
    case ($urandom_range(3))
      0: return C_MAX;
      1: return C_MIN;
      2: return 24'sd0;
      default: return -24'sd1;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic signed [23:0] x,
                           input logic signed [23:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {y, x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tracker.track_word(op, x, y);
  endtask

  // stop sending and let every owed result drain
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_radius(input logic [15:0] r);
    quiesce();
    cfg_data  <= r;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.radius = r;
  endtask

  // car position: mostly inside the radius of the current target, some on its rim
  task automatic send_position();
    logic signed [23:0] cx, cy, x, y;
    int span, pick, off;
    if (tracker.count != 0) begin
      cx = tracker.way_x[tracker.tgt];
      cy = tracker.way_y[tracker.tgt];
    end else begin
      cx = rand_coord();
      cy = rand_coord();
    end
    span = int'(tracker.radius) * 7 / 10;
    pick = $urandom_range(99);
    if (pick < 65) begin
      x = wrap_coord(longint'(cx) + longint'($urandom_range(2 * span)) - span);
      y = wrap_coord(longint'(cy) + longint'($urandom_range(2 * span)) - span);
    end else if (pick < 85) begin
      off = int'(tracker.radius) + int'($urandom_range(2)) - 1;
      if ($urandom_range(1)) off = -off;
      if ($urandom_range(1)) begin
        x = wrap_coord(longint'(cx) + off);
        y = cy;
      end else begin
        x = cx;
        y = wrap_coord(longint'(cy) + off);
      end
    end else begin
      x = rand_coord();
      y = rand_coord();
    end
    send_word(OP_POSITION, x, y);
  endtask

  // short courses: optional clear, a few waypoints, then laps of position updates
  task automatic run_courses(input int budget);
    int sent, k, pick;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 20) begin
        send_word(OP_CLEAR, rand_coord(), rand_coord());
        sent++;
      end
      k = $urandom_range(1, 8);
      repeat (k) begin
        send_word(OP_APPEND, pick_waypoint(), pick_waypoint());
        sent++;
      end
      k = $urandom_range(4, 24);
      repeat (k) begin
        pick = $urandom_range(99);
        if (pick < 88)
          send_position();
        else if (pick < 94)
          send_word(OP_APPEND, pick_waypoint(), pick_waypoint());
        else if (pick < 97)
          send_word(OP_UNUSED, rand_coord(), rand_coord());
        else
          send_word(OP_CLEAR, rand_coord(), rand_coord());
        sent++;
      end
    end
  endtask

  // fill past the table size, then drive through every entry and wrap
  task automatic fill_and_lap();
    send_word(OP_CLEAR, 24'sd0, 24'sd0);
    repeat (DEPTH + 3) send_word(OP_APPEND, pick_waypoint(), pick_waypoint());
    repeat (DEPTH + 10)
      send_word(OP_POSITION, tracker.way_x[tracker.tgt], tracker.way_y[tracker.tgt]);
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, range corners, rim of the default radius, wrap, clear
    send_word(OP_POSITION, C_MAX, C_MIN);
    send_word(OP_UNUSED, C_MIN, C_MAX);
    send_word(OP_APPEND, 24'sd0, 24'sd0);
    send_word(OP_APPEND, C_MAX, C_MAX);
    send_word(OP_APPEND, C_MIN, C_MIN);
    send_word(OP_APPEND, -24'sd1, 24'sd1);
    send_word(OP_POSITION, C_MIN, C_MAX);
    send_word(OP_POSITION, 24'sd1024, 24'sd0);
    send_word(OP_POSITION, 24'sd0, -24'sd1024);
    send_word(OP_POSITION, 24'sd1023, 24'sd0);
    send_word(OP_POSITION, C_MAX - 24'sd100, C_MAX - 24'sd100);
    send_word(OP_POSITION, C_MAX, C_MAX);
    send_word(OP_POSITION, C_MIN, C_MIN);
    send_word(OP_POSITION, -24'sd1, 24'sd1);
    send_word(OP_UNUSED, 24'sd0, 24'sd0);
    send_word(OP_APPEND, 24'sd5, 24'sd5);
    send_word(OP_POSITION, 24'sd0, 24'sd0);
    send_word(OP_CLEAR, C_MAX, C_MAX);
    send_word(OP_POSITION, 24'sd0, 24'sd0);
    send_word(OP_APPEND, C_MIN, C_MAX);

    // no idling, moderate radius
    set_radius(16'($urandom_range(256, 4096)));
    run_courses(220);

    // smallest nonzero radius: one waypoint, a capture and a lap on every update
    set_radius(16'd1);
    send_word(OP_CLEAR, 24'sd0, 24'sd0);
    send_word(OP_APPEND, rand_coord(), rand_coord());
    repeat (40) send_word(OP_POSITION, tracker.way_x[0], tracker.way_y[0]);

    // sender idles, largest radius, full table
    quiesce();
    idle_pct = 46;
    set_radius(16'hFFFF);
    fill_and_lap();
    run_courses(120);

    // receiver stalls, zero radius, then a random one
    quiesce();
    idle_pct  = 0;
    stall_pct = 46;
    set_radius(16'd0);
    run_courses(50);
    set_radius(16'($urandom_range(64, 8192)));
    run_courses(170);

    // both sides idle, radius anywhere in range
    quiesce();
    idle_pct  = 14;
    stall_pct = 14;
    set_radius(16'($urandom()));
    run_courses(210);

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
rtl/wcf_pkg.sv
rtl/wcf_mem.sv
rtl/wcf_dist.sv
rtl/waypoint_capture_follower.sv
tb/sv/tb_top.sv
